// ===== design/br_pkg.sv =====
// Shared codes, widths, curve tables and the decode stage word of the battery report decoder.
package br_pkg;

    // Frame formats
    localparam logic [2:0] KIND_UNIFIED = 3'd0;
    localparam logic [2:0] KIND_STATUS  = 3'd1;
    localparam logic [2:0] KIND_VOLTAGE = 3'd2;
    localparam logic [2:0] KIND_ADC     = 3'd3;
    localparam logic [2:0] KIND_SOC     = 3'd4;

    // Normalised charge states
    localparam logic [2:0] ST_UNKNOWN = 3'd0;
    localparam logic [2:0] ST_DIS     = 3'd1;
    localparam logic [2:0] ST_CHG     = 3'd2;
    localparam logic [2:0] ST_SLOW    = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;
    localparam logic [2:0] ST_ERR     = 3'd5;

    // Level codes
    localparam logic [2:0] LV_NONE = 3'd0;
    localparam logic [2:0] LV_CRIT = 3'd1;
    localparam logic [2:0] LV_LOW  = 3'd2;
    localparam logic [2:0] LV_GOOD = 3'd3;
    localparam logic [2:0] LV_FULL = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_LEVEL_MASK   = 2'd0;
    localparam logic [1:0] REG_CAP_FLAGS    = 2'd1;
    localparam logic [1:0] REG_CAPS_PRESENT = 2'd2;

    // Percent codes
    localparam logic [7:0] PCT_NONE = 8'hFF;
    localparam logic [7:0] PCT_MAX  = 8'd100;

    // Discharge curve, highest voltage first
    localparam int CURVE_POINTS = 13;
    localparam int SEGMENTS     = CURVE_POINTS - 1;
    localparam int MAX_STEPS    = 10;

    localparam logic [15:0] CURVE_MV [CURVE_POINTS] = '{
        16'd4186, 16'd4067, 16'd3989, 16'd3922, 16'd3859, 16'd3811, 16'd3778,
        16'd3751, 16'd3717, 16'd3671, 16'd3646, 16'd3579, 16'd3500
    };
    localparam logic [6:0] CURVE_PCT [CURVE_POINTS] = '{
        7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40,
        7'd30, 7'd20, 7'd10, 7'd5, 7'd2, 7'd0
    };

    // Offset above the segment's lower point at which each further percent is reached,
    // rounding half up; unused steps sit above any reachable offset.
    localparam logic [7:0] SEG_TH [SEGMENTS][MAX_STEPS] = '{
        '{8'd6, 8'd18, 8'd30, 8'd42, 8'd54, 8'd66, 8'd78, 8'd90, 8'd102, 8'd114},
        '{8'd4, 8'd12, 8'd20, 8'd28, 8'd36, 8'd43, 8'd51, 8'd59, 8'd67,  8'd75},
        '{8'd4, 8'd11, 8'd17, 8'd24, 8'd31, 8'd37, 8'd44, 8'd51, 8'd57,  8'd64},
        '{8'd4, 8'd10, 8'd16, 8'd23, 8'd29, 8'd35, 8'd41, 8'd48, 8'd54,  8'd60},
        '{8'd3, 8'd8,  8'd12, 8'd17, 8'd22, 8'd27, 8'd32, 8'd36, 8'd41,  8'd46},
        '{8'd2, 8'd5,  8'd9,  8'd12, 8'd15, 8'd19, 8'd22, 8'd25, 8'd29,  8'd32},
        '{8'd2, 8'd5,  8'd7,  8'd10, 8'd13, 8'd15, 8'd18, 8'd21, 8'd23,  8'd26},
        '{8'd2, 8'd6,  8'd9,  8'd12, 8'd16, 8'd19, 8'd23, 8'd26, 8'd29,  8'd33},
        '{8'd3, 8'd7,  8'd12, 8'd17, 8'd21, 8'd26, 8'd30, 8'd35, 8'd40,  8'd44},
        '{8'd3, 8'd8,  8'd13, 8'd18, 8'd23, 8'hFF, 8'hFF, 8'hFF, 8'hFF,  8'hFF},
        '{8'd12, 8'd34, 8'd56, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
        '{8'd20, 8'd60, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}
    };

    // Word leaving the format decode stage
    typedef struct packed {
        logic        valid_res;
        logic [7:0]  pct;
        logic        inferred;
        logic [2:0]  state;
        logic [2:0]  level;
        logic [15:0] mv;
        logic [7:0]  ext;
        logic        is_volt;
        logic        mv_high;
        logic        mv_above_low;
        logic        mv_zero;
        logic [11:1] mv_ge;
    } dec_t;

endpackage

// ===== design/br_frame_if.sv =====
// Report frame channel: valid/ready and the frame payload.
interface br_frame_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [2:0] frame_len;

    modport source (output valid, kind, byte0, byte1, byte2, byte3, frame_len, input ready);
    modport sink   (input valid, kind, byte0, byte1, byte2, byte3, frame_len, output ready);
endinterface

// ===== design/br_result_if.sv =====
// Decoded result channel: valid/ready and the reading fields.
interface br_result_if;
    logic              valid;
    logic              ready;
    logic              valid_res;
    logic signed [7:0] percent;
    logic              percent_inferred;
    logic [2:0]        charge_state;
    logic [2:0]        level_code;
    logic [15:0]       voltage_mv;
    logic [7:0]        external_power;

    modport source (output valid, valid_res, percent, percent_inferred, charge_state,
                    level_code, voltage_mv, external_power, input ready);
    modport sink   (input valid, valid_res, percent, percent_inferred, charge_state,
                    level_code, voltage_mv, external_power, output ready);
endinterface

// ===== design/br_cfg_if.sv =====
// Configuration write channel: valid/ready, register index and write data.
interface br_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/battery_report_decoder.sv =====
// Battery report decoder top level: config registers and the three-stage decode pipeline.
//
//  channel | modport | word
//  --------+---------+-------------------------------------------------------------
//  frame   | sink    | kind, byte0..byte3, frame_len
//  result  | source  | valid_res, percent, percent_inferred, charge_state, level_code,
//          |         | voltage_mv, external_power
//  cfg     | sink    | index (0 level mask, 1 cap flags, 2 caps present), data
//
// Three register stages: format decode, curve segment select, step count and merge.
// One frame per cycle while the result is not stalled; a frame passes the stage 1, 2 and 3 registers in turn.
// Each stage advances when it is empty or the stage after it advances, so a stalled
// result backs the pipeline up without loss and frame.ready stays high while there is room.
// rst_n clears the stage valid bits and the config registers; cfg writes are always ready.
module battery_report_decoder (
    input  logic clk,
    input  logic rst_n,
    br_frame_if.sink    frame,
    br_result_if.source result,
    br_cfg_if.sink      cfg
);
    import br_pkg::*;

    typedef enum logic [1:0] {RGN_MID, RGN_HIGH, RGN_LOW, RGN_ZERO} region_t;

    typedef struct packed {
        dec_t       dec;
        region_t    region;
        logic [3:0] seg;
        logic [6:0] offs;
    } seg_word_t;

    typedef struct packed {
        logic       valid_res;
        logic [7:0] pct;
        logic       inferred;
        logic [2:0] state;
        logic [2:0] level;
        logic [15:0] mv;
        logic [7:0] ext;
    } res_t;

    logic [7:0] level_mask_reg;
    logic [7:0] cap_flags_reg;
    logic [1:0] caps_present_reg;

    logic       v1_reg, v2_reg, v3_reg;
    dec_t       s1_reg;
    seg_word_t  s2_reg;
    res_t       s3_reg;

    dec_t       dec_next;
    seg_word_t  s2_next;
    res_t       s3_next;
    logic       adv1, adv2, adv3;

    logic [3:0] seg;
    logic [3:0] seg_p1;
    logic [15:0] offs_full;
    logic [MAX_STEPS-1:0] hits;
    logic [3:0] steps;
    logic [7:0] curve_pct;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_mask_reg   <= '0;
            cap_flags_reg    <= '0;
            caps_present_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_LEVEL_MASK:   level_mask_reg   <= cfg.data;
                REG_CAP_FLAGS:    cap_flags_reg    <= cfg.data;
                REG_CAPS_PRESENT: caps_present_reg <= cfg.data[1:0];
                default:          ;
            endcase
        end
    end

    // stage advance chain
    assign adv3        = !v3_reg || result.ready;
    assign adv2        = !v2_reg || adv3;
    assign adv1        = !v1_reg || adv2;
    assign frame.ready = adv1;

    // stage 1: format decode
    br_fmt_decode u_fmt (
        .kind           (frame.kind),
        .byte0          (frame.byte0),
        .byte1          (frame.byte1),
        .byte2          (frame.byte2),
        .byte3          (frame.byte3),
        .frame_len      (frame.frame_len),
        .cap_level_mask (level_mask_reg),
        .cap_flags      (cap_flags_reg),
        .caps_present   (caps_present_reg),
        .dec            (dec_next)
    );

    // stage 2: curve segment and offset above its lower point
    always_comb
    begin
        seg = 4'(SEGMENTS - 1);
        for (int i = 10; i >= 0; i--)
        begin
            if (s1_reg.mv_ge[i+1])
                seg = 4'(i);
        end
    end

    assign seg_p1    = seg + 4'd1;
    assign offs_full = s1_reg.mv - CURVE_MV[seg_p1];

    always_comb
    begin
        s2_next.dec  = s1_reg;
        s2_next.seg  = seg;
        s2_next.offs = offs_full[6:0];
        if (s1_reg.mv_high)
            s2_next.region = RGN_HIGH;
        else if (!s1_reg.mv_above_low)
            s2_next.region = s1_reg.mv_zero ? RGN_ZERO : RGN_LOW;
        else
            s2_next.region = RGN_MID;
    end

    // stage 3: count percent steps passed and merge
    always_comb
    begin
        for (int k = 0; k < MAX_STEPS; k++)
        begin
            hits[k] = {1'b0, s2_reg.offs} >= SEG_TH[s2_reg.seg][k];
        end
    end

    assign steps = 4'($countones(hits));

    always_comb
    begin
        unique case (s2_reg.region)
            RGN_HIGH: curve_pct = PCT_MAX;
            RGN_LOW:  curve_pct = 8'd0;
            RGN_ZERO: curve_pct = PCT_NONE;
            default:  curve_pct = {1'b0, CURVE_PCT[s2_reg.seg + 4'd1]} + {4'd0, steps};
        endcase
    end

    always_comb
    begin
        s3_next.state = s2_reg.dec.state;
        s3_next.level = s2_reg.dec.level;
        s3_next.mv    = s2_reg.dec.mv;
        s3_next.ext   = s2_reg.dec.ext;
        if (s2_reg.dec.is_volt)
        begin
            s3_next.pct       = curve_pct;
            s3_next.inferred  = !curve_pct[7];
            s3_next.valid_res = !curve_pct[7];
        end
        else
        begin
            s3_next.pct       = s2_reg.dec.pct;
            s3_next.inferred  = s2_reg.dec.inferred;
            s3_next.valid_res = s2_reg.dec.valid_res;
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= frame.valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    // stage words
    always_ff @(posedge clk)
    begin
        if (adv1) s1_reg <= dec_next;
        if (adv2) s2_reg <= s2_next;
        if (adv3) s3_reg <= s3_next;
    end

    // result port
    assign result.valid            = v3_reg;
    assign result.valid_res        = s3_reg.valid_res;
    assign result.percent          = s3_reg.pct;
    assign result.percent_inferred = s3_reg.inferred;
    assign result.charge_state     = s3_reg.state;
    assign result.level_code       = s3_reg.level;
    assign result.voltage_mv       = s3_reg.mv;
    assign result.external_power   = s3_reg.ext;

    // checks
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (s3_reg.pct == PCT_NONE || s3_reg.pct <= PCT_MAX))
        else $error("percent outside -1..100");

    a_inferred_known: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && s3_reg.inferred |-> !s3_reg.pct[7])
        else $error("inferred percent marked unknown");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && v2_reg && v3_reg && !result.ready |-> !frame.ready)
        else $error("frame taken into a full stalled pipeline");

    a_stage2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && v3_reg && !result.ready |=> v2_reg && $stable(s2_reg.seg)
                                             && $stable(s2_reg.offs))
        else $error("stage 2 word lost under stall");

    a_mid_offset: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && s2_reg.dec.is_volt && s2_reg.region == RGN_MID |-> s2_reg.offs <= 7'd119)
        else $error("curve offset beyond widest segment");

endmodule

// ===== design/br_fmt_decode.sv =====
// Format decode stage: per-kind field rules and the curve compares on the voltage.
module br_fmt_decode (
    input  logic [2:0]   kind,
    input  logic [7:0]   byte0,
    input  logic [7:0]   byte1,
    input  logic [7:0]   byte2,
    input  logic [7:0]   byte3,
    input  logic [2:0]   frame_len,
    input  logic [7:0]   cap_level_mask,
    input  logic [7:0]   cap_flags,
    input  logic [1:0]   caps_present,
    output br_pkg::dec_t dec
);
    import br_pkg::*;

    logic       has1, has2, has3, has4;
    logic       soc;
    logic [7:0] bits;
    logic [7:0] clamped;
    logic [7:0] fl;
    logic [15:0] mv;

    // level from the highest flag set
    function automatic logic [2:0] level_of_bits(input logic [3:0] b);
        logic [2:0] l;
        l = LV_NONE;
        if (b[3])      l = LV_FULL;
        else if (b[2]) l = LV_GOOD;
        else if (b[1]) l = LV_LOW;
        else if (b[0]) l = LV_CRIT;
        return l;
    endfunction

    // approximate percent for the highest flag set
    function automatic logic [7:0] approx_of_bits(input logic [3:0] b);
        logic [7:0] p;
        p = PCT_NONE;
        if (b[3])      p = 8'd90;
        else if (b[2]) p = 8'd50;
        else if (b[1]) p = 8'd20;
        else if (b[0]) p = 8'd5;
        return p;
    endfunction

    // byte presence and shared pieces
    assign has1    = frame_len >= 3'd1;
    assign has2    = frame_len >= 3'd2;
    assign has3    = frame_len >= 3'd3;
    assign has4    = frame_len >= 3'd4;
    assign soc     = (caps_present < 2'd2) || cap_flags[1];
    assign bits    = (has2 ? byte1 : 8'd0) & (soc ? 8'hFF : cap_level_mask);
    assign clamped = (byte0 > PCT_MAX) ? PCT_MAX : byte0;
    assign fl      = has3 ? byte2 : 8'd0;
    assign mv      = {byte0, byte1};

    // per-format rules
    always_comb
    begin
        dec              = '0;
        dec.pct          = PCT_NONE;
        dec.mv_high      = mv >= CURVE_MV[0];
        dec.mv_above_low = mv > CURVE_MV[CURVE_POINTS-1];
        dec.mv_zero      = mv == 16'd0;
        for (int i = 1; i <= 11; i++)
        begin
            dec.mv_ge[i] = mv >= CURVE_MV[i];
        end

        unique case (kind)
            KIND_UNIFIED:
            begin
                if (has1)
                begin
                    dec.level = level_of_bits(bits[3:0]);
                    if (has3)
                    begin
                        unique case (byte2)
                            8'd0:    dec.state = ST_DIS;
                            8'd1:    dec.state = ST_CHG;
                            8'd2:    dec.state = ST_SLOW;
                            8'd3:    dec.state = ST_FULL;
                            8'd4:    dec.state = ST_ERR;
                            default: dec.state = ST_UNKNOWN;
                        endcase
                    end
                    dec.ext = has4 ? byte3 : 8'd0;
                    if (soc)
                    begin
                        dec.pct = clamped;
                    end
                    else
                    begin
                        dec.pct      = approx_of_bits(bits[3:0]);
                        dec.inferred = bits[3:0] != 4'd0;
                    end
                    dec.valid_res = !dec.pct[7] || (dec.level != LV_NONE)
                                    || (dec.state != ST_UNKNOWN);
                end
            end
            KIND_STATUS:
            begin
                if (has1)
                begin
                    dec.pct = clamped;
                    if (has3)
                    begin
                        unique case (byte2) inside
                            8'd0:       dec.state = ST_DIS;
                            8'd1, 8'd2: dec.state = ST_CHG;
                            8'd3:       dec.state = ST_FULL;
                            8'd4:       dec.state = ST_SLOW;
                            8'd5, 8'd6: dec.state = ST_ERR;
                            default:    dec.state = ST_UNKNOWN;
                        endcase
                    end
                    if (clamped < 8'd11)      dec.level = LV_CRIT;
                    else if (clamped < 8'd30) dec.level = LV_LOW;
                    else if (clamped < 8'd81) dec.level = LV_GOOD;
                    else                      dec.level = LV_FULL;
                    dec.valid_res = 1'b1;
                end
            end
            KIND_VOLTAGE:
            begin
                if (has2)
                begin
                    dec.mv      = mv;
                    dec.is_volt = 1'b1;
                    if (fl[7])
                    begin
                        unique case (fl[2:0])
                            3'd0:    dec.state = ST_CHG;
                            3'd1:    dec.state = ST_FULL;
                            3'd2:    dec.state = ST_DIS;
                            default: dec.state = ST_UNKNOWN;
                        endcase
                    end
                    else
                    begin
                        dec.state = ST_DIS;
                    end
                    if (fl[4])
                        dec.state = ST_SLOW;
                    else if (fl[3] && dec.state == ST_DIS)
                        dec.state = ST_CHG;
                    dec.level = fl[5] ? LV_CRIT : LV_NONE;
                end
            end
            KIND_ADC:
            begin
                if (has2)
                begin
                    dec.mv      = mv;
                    dec.is_volt = 1'b1;
                    dec.state   = (fl[0] && fl[1]) ? ST_CHG : ST_DIS;
                end
            end
            KIND_SOC:
            begin
                if (has1)
                begin
                    dec.pct = clamped;
                    unique case (fl) inside
                        8'd1, 8'd2: dec.state = ST_CHG;
                        8'd3:       dec.state = ST_FULL;
                        default:    dec.state = ST_DIS;
                    endcase
                    dec.valid_res = 1'b1;
                end
            end
            default:
            begin
                dec.pct = PCT_NONE;
            end
        endcase
    end

endmodule
